FILE: rtl/core/sars_pkg.sv
// Package with the beat types, field widths and status codes of the region statistics unit.
package sars_pkg;

	localparam int DIM_W = 13;
	localparam int CFG_W = 9;
	localparam int SUM_W = 24;
	localparam int SQ_W = 32;
	localparam int AREA_W = 17;
	localparam int DEV_W = 40;
	localparam int PROD_W = 49;
	localparam int TOTAL_W = 50;
	localparam int DVD_W = 58;
	localparam int ENTRY_W = 3 * SUM_W + 3 * SQ_W;
	localparam int DEF_MAX_WIDTH = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_RECT = 2'd1;
	localparam logic [1:0] ST_NOT_LOADED = 2'd2;

	localparam logic CFG_IMAGE_WIDTH = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic action;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] top_row;
		logic [7:0] left_col;
		logic [7:0] bottom_row;
		logic [7:0] right_col;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] avg_red;
		logic [7:0] avg_green;
		logic [7:0] avg_blue;
		logic [AREA_W-1:0] area;
		logic [DEV_W-1:0] sq_dev_q8;
	} out_beat_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

FILE: rtl/core/sars_stream_if.sv
// Valid/ready stream interface that carries one beat of a given payload type.
interface sars_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/sars_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module sars_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/sars_div.sv
// Restoring divider that produces one quotient bit per cycle.
module sars_div #(
	parameter int DVD_W = 58,
	parameter int DVS_W = 17
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DVD_W-1:0] dividend,
	input logic [DVS_W-1:0] divisor,
	output sars_pkg::div_ctl_t ctl,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W:0] trial;
	logic fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
	assign quotient = dvd_q;
endmodule

FILE: rtl/core/summed_area_region_stats_unit.sv
// Top level of the summed-area region statistics unit.
//
//   channel   dir   payload                                   accepted when
//   in_ch     in    action, pixel, query rectangle            valid && ready
//   out_ch    out   status, averages, area, sq_dev_q8         valid && ready
//   cfg       in    cfg_wr_en, cfg_index, cfg_data            cfg_wr_en
//
// A load reads the entry above through the table RAM and then writes the new entry back.
// A query with an error status goes straight to the result hand-off; a valid query runs
// four corner reads, a multiply and an add step per channel and four divisions in one divider.
// Reset clears the load position, the running sums and the loaded flag; the RAM is not cleared.
// A finished result waits in the output register; a query holds in S_OUT while out_ch stalls.
module summed_area_region_stats_unit #(
	parameter int MAX_WIDTH = sars_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sars_pkg::DEF_MAX_HEIGHT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic cfg_index,
	input logic [sars_pkg::CFG_W-1:0] cfg_data,
	sars_stream_if.sink in_ch,
	sars_stream_if.source out_ch
);
	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int DW = sars_pkg::DIM_W;
	localparam int SW = sars_pkg::SUM_W;
	localparam int QW = sars_pkg::SQ_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LRD = 4'd1;
	localparam logic [3:0] S_LWR = 4'd2;
	localparam logic [3:0] S_QRD = 4'd3;
	localparam logic [3:0] S_QLAST = 4'd4;
	localparam logic [3:0] S_MUL = 4'd5;
	localparam logic [3:0] S_ADD = 4'd6;
	localparam logic [3:0] S_DGO = 4'd7;
	localparam logic [3:0] S_DWAIT = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;

	localparam logic [1:0] C_ALL = 2'd0;
	localparam logic [1:0] C_ABOVE = 2'd1;
	localparam logic [1:0] C_BESIDE = 2'd2;
	localparam logic [1:0] C_CORNER = 2'd3;

	logic [3:0] state_q;
	logic [sars_pkg::CFG_W-1:0] width_q;
	logic [sars_pkg::CFG_W-1:0] height_q;
	logic [DW-1:0] eff_w;
	logic [DW-1:0] eff_h;
	logic [DW-1:0] col_q;
	logic [DW-1:0] row_q;
	logic complete_q;
	logic [SW-1:0] rs_sum_q [3];
	logic [QW-1:0] rs_sq_q [3];
	logic [7:0] pix_q [3];

	logic [7:0] top_q, left_q, bottom_q, right_q;
	logic [sars_pkg::AREA_W-1:0] n_q;
	logic [1:0] cnt_q;
	logic [1:0] corner_s1;
	logic use_s1;
	logic vld_s1;
	logic [SW-1:0] acc_sum_q [3];
	logic [QW-1:0] acc_sq_q [3];
	logic [1:0] ch_q;
	logic [sars_pkg::PROD_W-1:0] prod_a_s1;
	logic [sars_pkg::PROD_W-1:0] prod_b_s1;
	logic [sars_pkg::TOTAL_W-1:0] total_q;
	sars_pkg::out_beat_t res_q;
	sars_pkg::out_beat_t res_init;
	sars_pkg::out_beat_t out_data_q;
	logic out_valid_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [sars_pkg::ENTRY_W-1:0] ram_wdata;
	logic [sars_pkg::ENTRY_W-1:0] ram_rdata;

	logic div_start;
	logic [sars_pkg::DVD_W-1:0] div_dividend;
	logic [sars_pkg::DVD_W-1:0] div_quot;
	sars_pkg::div_ctl_t div_ctl;

	logic in_acc;
	logic bad_rect;
	logic [8:0] n_h, n_w;
	logic [17:0] n_full;
	logic [SW-1:0] new_sum [3];
	logic [QW-1:0] new_sq [3];
	logic [SW-1:0] new_rs [3];
	logic [QW-1:0] new_rsq [3];

	function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] r, input logic [DW-1:0] c);
		logic [31:0] full;
		full = 32'(r) * 32'(MAX_WIDTH) + 32'(c);
		return full[AW-1:0];
	endfunction

	always_comb begin
		if (width_q == '0) begin
			eff_w = DW'(1);
		end else if (DW'(width_q) > DW'(MAX_WIDTH)) begin
			eff_w = DW'(MAX_WIDTH);
		end else begin
			eff_w = DW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = DW'(1);
		end else if (DW'(height_q) > DW'(MAX_HEIGHT)) begin
			eff_h = DW'(MAX_HEIGHT);
		end else begin
			eff_h = DW'(height_q);
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign bad_rect = (in_ch.data.top_row > in_ch.data.bottom_row)
		|| (in_ch.data.left_col > in_ch.data.right_col)
		|| (DW'(in_ch.data.bottom_row) >= eff_h)
		|| (DW'(in_ch.data.right_col) >= eff_w);
	assign n_h = 9'(in_ch.data.bottom_row) - 9'(in_ch.data.top_row) + 9'd1;
	assign n_w = 9'(in_ch.data.right_col) - 9'(in_ch.data.left_col) + 9'd1;
	assign n_full = n_h * n_w;

	always_comb begin
		res_init = '0;
		if (!complete_q) begin
			res_init.status = sars_pkg::ST_NOT_LOADED;
		end else if (bad_rect) begin
			res_init.status = sars_pkg::ST_BAD_RECT;
		end else begin
			res_init.status = sars_pkg::ST_OK;
			res_init.area = sars_pkg::AREA_W'(n_full);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			new_rs[c] = rs_sum_q[c] + SW'(pix_q[c]);
			new_rsq[c] = rs_sq_q[c] + QW'(16'(pix_q[c]) * 16'(pix_q[c]));
			if (row_q != '0) begin
				new_sum[c] = new_rs[c] + ram_rdata[SW*c +: SW];
				new_sq[c] = new_rsq[c] + ram_rdata[3*SW + QW*c +: QW];
			end else begin
				new_sum[c] = new_rs[c];
				new_sq[c] = new_rsq[c];
			end
		end
		ram_wdata = {new_sq[2], new_sq[1], new_sq[0], new_sum[2], new_sum[1], new_sum[0]};
	end

	assign ram_we = (state_q == S_LWR);
	assign ram_waddr = cell_addr(row_q, col_q);

	always_comb begin
		ram_raddr = cell_addr(row_q - DW'(1), col_q);
		if (state_q == S_QRD) begin
			unique case (cnt_q)
				C_ALL: ram_raddr = cell_addr(DW'(bottom_q), DW'(right_q));
				C_ABOVE: ram_raddr = cell_addr(DW'(top_q) - DW'(1), DW'(right_q));
				C_BESIDE: ram_raddr = cell_addr(DW'(bottom_q), DW'(left_q) - DW'(1));
				C_CORNER: ram_raddr = cell_addr(DW'(top_q) - DW'(1), DW'(left_q) - DW'(1));
				default: ram_raddr = cell_addr(DW'(bottom_q), DW'(right_q));
			endcase
		end
	end

	assign div_start = (state_q == S_DGO);
	assign div_dividend = (ch_q == 2'd3)
		? {total_q, 8'd0}
		: sars_pkg::DVD_W'(acc_sum_q[ch_q]);

	sars_ram #(
		.WIDTH(sars_pkg::ENTRY_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sars_div #(
		.DVD_W(sars_pkg::DVD_W),
		.DVS_W(sars_pkg::AREA_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(n_q),
		.ctl(div_ctl),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= sars_pkg::CFG_W'(256);
			height_q <= sars_pkg::CFG_W'(256);
			col_q <= '0;
			row_q <= '0;
			complete_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				rs_sum_q[c] <= '0;
				rs_sq_q[c] <= '0;
			end
			cnt_q <= '0;
			ch_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_QRD);
			if (state_q == S_OUT && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				if (cfg_index == sars_pkg::CFG_IMAGE_WIDTH) begin
					width_q <= cfg_data;
				end else begin
					height_q <= cfg_data;
				end
				col_q <= '0;
				row_q <= '0;
				complete_q <= 1'b0;
				for (int c = 0; c < 3; c++) begin
					rs_sum_q[c] <= '0;
					rs_sq_q[c] <= '0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.data.action == sars_pkg::ACT_LOAD) begin
							if (complete_q) begin
								col_q <= '0;
								row_q <= '0;
								complete_q <= 1'b0;
							end
							if (complete_q || col_q == '0) begin
								for (int c = 0; c < 3; c++) begin
									rs_sum_q[c] <= '0;
									rs_sq_q[c] <= '0;
								end
							end
							state_q <= S_LRD;
						end else if (!complete_q || bad_rect) begin
							state_q <= S_OUT;
						end else begin
							cnt_q <= '0;
							ch_q <= '0;
							state_q <= S_QRD;
						end
					end
				end
				S_LRD: state_q <= S_LWR;
				S_LWR: begin
					for (int c = 0; c < 3; c++) begin
						rs_sum_q[c] <= new_rs[c];
						rs_sq_q[c] <= new_rsq[c];
					end
					if (col_q + DW'(1) >= eff_w) begin
						col_q <= '0;
						if (row_q + DW'(1) >= eff_h) begin
							row_q <= '0;
							complete_q <= 1'b1;
						end else begin
							row_q <= row_q + DW'(1);
						end
					end else begin
						col_q <= col_q + DW'(1);
					end
					state_q <= S_IDLE;
				end
				S_QRD: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == C_CORNER) begin
						state_q <= S_QLAST;
					end
				end
				S_QLAST: state_q <= S_MUL;
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (ch_q == 2'd2) begin
						ch_q <= '0;
						state_q <= S_DGO;
					end else begin
						ch_q <= ch_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_DGO: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_ctl.done) begin
						if (ch_q == 2'd3) begin
							state_q <= S_OUT;
						end else begin
							ch_q <= ch_q + 2'd1;
							state_q <= S_DGO;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		corner_s1 <= cnt_q;
		unique case (cnt_q)
			C_ALL: use_s1 <= 1'b1;
			C_ABOVE: use_s1 <= (top_q != '0);
			C_BESIDE: use_s1 <= (left_q != '0);
			C_CORNER: use_s1 <= (top_q != '0) && (left_q != '0);
			default: use_s1 <= 1'b0;
		endcase
		if (state_q == S_IDLE && in_acc) begin
			for (int c = 0; c < 3; c++) begin
				pix_q[c] <= (c == 0) ? in_ch.data.red_in
					: (c == 1) ? in_ch.data.green_in : in_ch.data.blue_in;
				acc_sum_q[c] <= '0;
				acc_sq_q[c] <= '0;
			end
			top_q <= in_ch.data.top_row;
			left_q <= in_ch.data.left_col;
			bottom_q <= in_ch.data.bottom_row;
			right_q <= in_ch.data.right_col;
			n_q <= sars_pkg::AREA_W'(n_full);
			total_q <= '0;
			res_q <= res_init;
		end
		if (vld_s1 && use_s1) begin
			for (int c = 0; c < 3; c++) begin
				if (corner_s1 == C_ALL || corner_s1 == C_CORNER) begin
					acc_sum_q[c] <= acc_sum_q[c] + ram_rdata[SW*c +: SW];
					acc_sq_q[c] <= acc_sq_q[c] + ram_rdata[3*SW + QW*c +: QW];
				end else begin
					acc_sum_q[c] <= acc_sum_q[c] - ram_rdata[SW*c +: SW];
					acc_sq_q[c] <= acc_sq_q[c] - ram_rdata[3*SW + QW*c +: QW];
				end
			end
		end
		if (state_q == S_MUL) begin
			prod_a_s1 <= sars_pkg::PROD_W'(n_q) * sars_pkg::PROD_W'(acc_sq_q[ch_q]);
			prod_b_s1 <= sars_pkg::PROD_W'(acc_sum_q[ch_q]) * sars_pkg::PROD_W'(acc_sum_q[ch_q]);
		end
		if (state_q == S_ADD && prod_a_s1 > prod_b_s1) begin
			total_q <= total_q + sars_pkg::TOTAL_W'(prod_a_s1 - prod_b_s1);
		end
		if (state_q == S_DWAIT && div_ctl.done) begin
			unique case (ch_q)
				2'd0: res_q.avg_red <= div_quot[7:0];
				2'd1: res_q.avg_green <= div_quot[7:0];
				2'd2: res_q.avg_blue <= div_quot[7:0];
				default: begin
					if (div_quot[sars_pkg::DVD_W-1:sars_pkg::DEV_W] != '0) begin
						res_q.sq_dev_q8 <= '1;
					end else begin
						res_q.sq_dev_q8 <= div_quot[sars_pkg::DEV_W-1:0];
					end
				end
			endcase
		end
		if (state_q == S_OUT && (!out_valid_q || out_ch.ready)) begin
			out_data_q <= res_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_data_q;

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result beat raised outside the result hand-off");

	a_ok_area: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.status == sars_pkg::ST_OK |-> out_data_q.area != '0)
		else $error("successful query reported an empty area");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.busy |-> state_q == S_DWAIT)
		else $error("divider running outside the division wait");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(state_q == S_LRD))
		else $error("table write without the preceding read of the row above");

endmodule

FILE: tb/sv/summed_area_region_stats_checker.sv
// Checker that mirrors the region statistics unit and compares every result beat.
module summed_area_region_stats_checker
	import sars_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	sars_stream_if in_ch,
	sars_stream_if out_ch,
	output int errors,
	output int pending
);

	localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam logic [DEV_W-1:0] DEV_SAT = '1;

	logic [CFG_W-1:0] width_reg, height_reg;
	logic [SUM_W-1:0] sum_tab [3][CELLS];
	logic [SQ_W-1:0] sq_tab [3][CELLS];
	logic [SUM_W-1:0] row_sum [3];
	logic [SQ_W-1:0] row_sq [3];
	int load_col, load_row;
	bit complete;
	out_beat_t results_due [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic int eff_width();
		if (width_reg < 1) return 1;
		if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int eff_height();
		if (height_reg < 1) return 1;
		if (height_reg > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	task automatic restart_raster();
		load_col = 0;
		load_row = 0;
		complete = 0;
		for (int c = 0; c < 3; c++) begin
			row_sum[c] = '0;
			row_sq[c] = '0;
		end
	endtask

	task automatic accumulate_pixel(in_beat_t b);
		int idx;
		logic [7:0] v;
		logic [SUM_W-1:0] up_s;
		logic [SQ_W-1:0] up_q;
		if (complete)
			restart_raster();
		if (load_col == 0)
			for (int c = 0; c < 3; c++) begin
				row_sum[c] = '0;
				row_sq[c] = '0;
			end
		idx = load_row * DEF_MAX_WIDTH + load_col;
		for (int c = 0; c < 3; c++) begin
			v = (c == 0) ? b.red_in : (c == 1) ? b.green_in : b.blue_in;
			row_sum[c] = row_sum[c] + SUM_W'(v);
			row_sq[c] = row_sq[c] + SQ_W'(v) * SQ_W'(v);
			up_s = '0;
			up_q = '0;
			if (load_row > 0) begin
				up_s = sum_tab[c][idx - DEF_MAX_WIDTH];
				up_q = sq_tab[c][idx - DEF_MAX_WIDTH];
			end
			sum_tab[c][idx] = row_sum[c] + up_s;
			sq_tab[c][idx] = row_sq[c] + up_q;
		end
		load_col++;
		if (load_col >= eff_width()) begin
			load_col = 0;
			load_row++;
			if (load_row >= eff_height()) begin
				load_row = 0;
				complete = 1;
			end
		end
	endtask

	function automatic out_beat_t region_stats(in_beat_t b);
		out_beat_t r;
		int t, l, bo, ri;
		logic [SUM_W-1:0] s;
		logic [SQ_W-1:0] sq;
		logic [63:0] n, total, a, s2, q, rem, dev;
		r = '0;
		if (!complete) begin
			r.status = ST_NOT_LOADED;
			return r;
		end
		t = b.top_row;
		l = b.left_col;
		bo = b.bottom_row;
		ri = b.right_col;
		if (t > bo || l > ri || bo >= eff_height() || ri >= eff_width()) begin
			r.status = ST_BAD_RECT;
			return r;
		end
		n = 64'((bo - t + 1) * (ri - l + 1));
		total = 0;
		for (int c = 0; c < 3; c++) begin
			s = sum_tab[c][bo * DEF_MAX_WIDTH + ri];
			sq = sq_tab[c][bo * DEF_MAX_WIDTH + ri];
			if (t > 0) begin
				s = s - sum_tab[c][(t - 1) * DEF_MAX_WIDTH + ri];
				sq = sq - sq_tab[c][(t - 1) * DEF_MAX_WIDTH + ri];
			end
			if (l > 0) begin
				s = s - sum_tab[c][bo * DEF_MAX_WIDTH + l - 1];
				sq = sq - sq_tab[c][bo * DEF_MAX_WIDTH + l - 1];
			end
			if (t > 0 && l > 0) begin
				s = s + sum_tab[c][(t - 1) * DEF_MAX_WIDTH + l - 1];
				sq = sq + sq_tab[c][(t - 1) * DEF_MAX_WIDTH + l - 1];
			end
			a = n * 64'(sq);
			s2 = 64'(s) * 64'(s);
			if (c == 0) r.avg_red = 8'(64'(s) / n);
			else if (c == 1) r.avg_green = 8'(64'(s) / n);
			else r.avg_blue = 8'(64'(s) / n);
			if (a > s2) total += a - s2;
		end
		q = total / n;
		rem = total % n;
		if (q >= 64'h1_0000_0000) begin
			dev = 64'(DEV_SAT);
		end else begin
			dev = (q << 8) + (rem << 8) / n;
			if (dev > 64'(DEV_SAT)) dev = 64'(DEV_SAT);
		end
		r.status = ST_OK;
		r.area = AREA_W'(n);
		r.sq_dev_q8 = DEV_W'(dev);
		return r;
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t got, want;
		if (!arst_n) begin
			width_reg = CFG_W'(DEF_MAX_WIDTH);
			height_reg = CFG_W'(DEF_MAX_HEIGHT);
			restart_raster();
			results_due.delete();
			pending = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (results_due.size() == 0) begin
					$display("unexpected result beat at %0t", $realtime);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status) report("status", got.status, want.status);
					if (got.avg_red !== want.avg_red) report("avg_red", got.avg_red, want.avg_red);
					if (got.avg_green !== want.avg_green)
						report("avg_green", got.avg_green, want.avg_green);
					if (got.avg_blue !== want.avg_blue)
						report("avg_blue", got.avg_blue, want.avg_blue);
					if (got.area !== want.area) report("area", got.area, want.area);
					if (got.sq_dev_q8 !== want.sq_dev_q8)
						report("sq_dev_q8", got.sq_dev_q8, want.sq_dev_q8);
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == CFG_IMAGE_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
				restart_raster();
			end
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.data.action == ACT_LOAD) accumulate_pixel(in_ch.data);
				else results_due.push_back(region_stats(in_ch.data));
			end
			pending = results_due.size();
		end
	end

endmodule

FILE: tb/sv/summed_area_region_stats_unit_tb.sv
// Top of the region statistics testbench: clock, reset, stimulus and verdict.
module summed_area_region_stats_unit_tb;
	import sars_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int DRAIN_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int errors, pending, cycles, items;
	int send_idle, recv_stall;
	int img_w, img_h;

	sars_stream_if #(.T(in_beat_t)) in_ch ();
	sars_stream_if #(.T(out_beat_t)) out_ch ();

	summed_area_region_stats_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	summed_area_region_stats_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch), .errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_stall);

	task automatic send_beat(in_beat_t b);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= b;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		items++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_size(int w, int h);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= CFG_W'(w);
		@(negedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		img_w = (w < 1) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
		img_h = (h < 1) ? 1 : (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
	endtask

	function automatic in_beat_t pixel(int mode);
		in_beat_t b;
		b = in_beat_t'({$urandom, $urandom});
		b.action = ACT_LOAD;
		if (mode == 1) {b.red_in, b.green_in, b.blue_in} = '1;
		else if (mode == 2) {b.red_in, b.green_in, b.blue_in} = '0;
		return b;
	endfunction

	function automatic in_beat_t query(int t, int l, int bo, int r);
		in_beat_t b;
		b = in_beat_t'({$urandom, $urandom});
		b.action = ACT_QUERY;
		b.top_row = 8'(t);
		b.left_col = 8'(l);
		b.bottom_row = 8'(bo);
		b.right_col = 8'(r);
		return b;
	endfunction

	function automatic in_beat_t random_query();
		int t, l;
		if ($urandom_range(99) < 20) return query($urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255));
		t = $urandom_range(img_h - 1);
		l = $urandom_range(img_w - 1);
		return query(t, l, $urandom_range(img_h - 1, t), $urandom_range(img_w - 1, l));
	endfunction

	task automatic load_image(int mode);
		for (int i = 0; i < img_w * img_h; i++) begin
			if ($urandom_range(99) < 4) send_beat(random_query());
			send_beat(pixel(mode));
		end
	endtask

	initial begin
		int sizes [10][2];
		int mode;
		sizes = '{'{4, 3}, '{1, 1}, '{0, 0}, '{511, 2}, '{1, 200}, '{256, 1},
			'{7, 5}, '{16, 16}, '{1, 9}, '{-1, -1}};
		cycles = 0;
		items = 0;
		send_idle = 0;
		recv_stall = 0;
		img_w = DEF_MAX_WIDTH;
		img_h = DEF_MAX_HEIGHT;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(query(0, 0, 0, 0));
		set_size(4, 3);
		for (int i = 0; i < 12; i++) send_beat(pixel(i % 3));
		send_beat(query(0, 0, 2, 3));
		send_beat(query(0, 0, 0, 0));
		send_beat(query(2, 3, 2, 3));
		send_beat(query(1, 1, 2, 2));
		send_beat(query(2, 0, 1, 3));
		send_beat(query(0, 3, 2, 1));
		send_beat(query(0, 0, 3, 3));
		send_beat(query(0, 0, 2, 4));
		send_beat(query(255, 255, 255, 255));
		send_beat(pixel(0));
		send_beat(query(0, 0, 0, 0));

		for (int p = 0; items < 1500; p++) begin
			drain();
			if (sizes[p % 10][0] < 0) set_size($urandom_range(1, 12), $urandom_range(1, 12));
			else set_size(sizes[p % 10][0], sizes[p % 10][1]);
			for (int img = 0; img < 2; img++) begin
				mode = (p * 2 + img) % 4;
				send_idle = (mode == 1 || mode == 3) ? ((mode == 1) ? 68 : 33) : 0;
				recv_stall = (mode == 2 || mode == 3) ? ((mode == 2) ? 68 : 33) : 0;
				load_image($urandom_range(9) == 0 ? 1 + img : 0);
				for (int k = 0; k < 8; k++) begin
					if (k == 4 && p % 3 == 0) drain();
					send_beat(random_query());
				end
			end
		end

		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
